>>> rtl/core/lgrid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgrid_pkg
// shared constants, codes and helpers of the layered occupancy grid
// ----------------------------------------------------------------------------
package lgrid_pkg;

    localparam int MAX_ROWS_DEF  = 64;
    localparam int MAX_COLS_DEF  = 64;
    localparam int MASK_BITS_DEF = 32;

    localparam int CFG_W    = 7;
    localparam int COORD_W  = 16;
    localparam int LAYER_W  = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 1;

    localparam logic [CFG_W-1:0] ROWS_RESET = 7'd64;
    localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

    localparam logic [INDEX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [INDEX_W-1:0] REG_COLS = 1'b1;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MOVE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_COLLIDE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOOP    = 2'd3;

    // coordinate is non-negative and below both the live count and the maximum
    function automatic logic coord_ok(
        input logic [COORD_W-1:0] v,
        input logic [CFG_W-1:0]   lim,
        input logic [COORD_W-1:0] maxv
    );
        logic ok;
        ok = !v[COORD_W-1] && (v < {{(COORD_W-CFG_W){1'b0}}, lim}) && (v < maxv);
        return ok;
    endfunction

endpackage

>>> rtl/core/lgrid_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgrid_mem
// cell mask store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module lgrid_mem #(
    parameter int DEPTH  = lgrid_pkg::MAX_ROWS_DEF * lgrid_pkg::MAX_COLS_DEF,
    parameter int WIDTH  = lgrid_pkg::MASK_BITS_DEF,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/layered_occupancy_grid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layered_occupancy_grid
// grid of per-cell layer masks with insert, move and remove items
//
// an item is taken when start is high and busy is low; mode, target, source
// and layer_bits are sampled at that edge. one result per item: status is
// valid for the single cycle in which done is high, and the receiver cannot
// stall it. cfg writes (wr_en, wr_index, wr_data) land at once, no wait.
// steps from accept to done:
//   mode three, a target off the grid, a move onto itself: done next cycle
//   insert, remove, a colliding move or a move whose source is off the grid:
//            target read, then ST_EVAL writes it back unless it collides
//   any other move: the source read goes with the target write in ST_EVAL,
//            then ST_SRC writes the source cell back
// busy is low when done rises, so a new item can enter there, but none is
// taken during the read-modify-write of the single write port memory.
// after reset the memory is cleared one cell a cycle, busy high until the
// last cell is cleared; cfg writes are taken during that pass.
// ----------------------------------------------------------------------------
module layered_occupancy_grid #(
    parameter int MAX_ROWS  = lgrid_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS  = lgrid_pkg::MAX_COLS_DEF,
    parameter int MASK_BITS = lgrid_pkg::MASK_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [lgrid_pkg::INDEX_W-1:0]     wr_index,
    input  logic [lgrid_pkg::CFG_W-1:0]       wr_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [lgrid_pkg::MODE_W-1:0]      mode,
    input  logic signed [lgrid_pkg::COORD_W-1:0] target_row,
    input  logic signed [lgrid_pkg::COORD_W-1:0] target_col,
    input  logic signed [lgrid_pkg::COORD_W-1:0] source_row,
    input  logic signed [lgrid_pkg::COORD_W-1:0] source_col,
    input  logic [lgrid_pkg::LAYER_W-1:0]     layer_bits,
    output logic                              done,
    output logic [lgrid_pkg::STATUS_W-1:0]    status
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CELL_W = (MASK_BITS < lgrid_pkg::LAYER_W) ? MASK_BITS : lgrid_pkg::LAYER_W;
    localparam int CW     = lgrid_pkg::COORD_W;
    localparam logic [CW-1:0]     MAX_ROWS_C = CW'(MAX_ROWS);
    localparam logic [CW-1:0]     MAX_COLS_C = CW'(MAX_COLS);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;
    localparam logic [1:0] ST_SRC   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [lgrid_pkg::CFG_W-1:0] rows_reg, cols_reg;
    logic done_reg, done_next;
    logic [lgrid_pkg::STATUS_W-1:0] status_reg, status_next;

    logic [lgrid_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [CELL_W-1:0] bits_reg, bits_next;
    logic [ADDR_W-1:0] taddr_reg, taddr_next;
    logic [ADDR_W-1:0] saddr_reg, saddr_next;
    logic sok_reg, sok_next;

    logic accept, t_ok, s_ok, same_cell, hit;
    logic [ADDR_W-1:0] t_addr, s_addr;
    logic mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata, mem_rdata;

    assign accept    = start && (state_reg == ST_IDLE);
    assign t_ok      = lgrid_pkg::coord_ok(target_row, rows_reg, MAX_ROWS_C)
                    && lgrid_pkg::coord_ok(target_col, cols_reg, MAX_COLS_C);
    assign s_ok      = lgrid_pkg::coord_ok(source_row, rows_reg, MAX_ROWS_C)
                    && lgrid_pkg::coord_ok(source_col, cols_reg, MAX_COLS_C);
    assign same_cell = (source_row == target_row) && (source_col == target_col);
    assign t_addr    = ADDR_W'(32'(target_row[CW-2:0]) * MAX_COLS + 32'(target_col[CW-2:0]));
    assign s_addr    = ADDR_W'(32'(source_row[CW-2:0]) * MAX_COLS + 32'(source_col[CW-2:0]));
    assign hit       = |(mem_rdata & bits_reg);

    lgrid_mem #(
        .DEPTH  (DEPTH),
        .WIDTH  (CELL_W),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        mode_next    = mode_reg;
        bits_next    = bits_reg;
        taddr_next   = taddr_reg;
        saddr_next   = saddr_reg;
        sok_next     = sok_reg;
        mem_we       = 1'b0;
        mem_waddr    = taddr_reg;
        mem_wdata    = mem_rdata | bits_reg;
        mem_re       = 1'b0;
        mem_raddr    = t_addr;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = mode;
                    bits_next  = layer_bits[CELL_W-1:0];
                    taddr_next = t_addr;
                    saddr_next = s_addr;
                    sok_next   = s_ok;
                    if (mode == lgrid_pkg::MODE_NONE)
                    begin
                        done_next   = 1'b1;
                        status_next = lgrid_pkg::STATUS_NOOP;
                    end
                    else if (!t_ok)
                    begin
                        done_next   = 1'b1;
                        status_next = lgrid_pkg::STATUS_OUTSIDE;
                    end
                    else if ((mode == lgrid_pkg::MODE_MOVE) && same_cell)
                    begin
                        done_next   = 1'b1;
                        status_next = lgrid_pkg::STATUS_NOOP;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL:
            begin
                done_next   = 1'b1;
                status_next = lgrid_pkg::STATUS_OK;
                state_next  = ST_IDLE;
                if (mode_reg == lgrid_pkg::MODE_REMOVE)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata & ~bits_reg;
                end
                else if (hit)
                begin
                    status_next = lgrid_pkg::STATUS_COLLIDE;
                end
                else
                begin
                    mem_we = 1'b1;
                    if ((mode_reg == lgrid_pkg::MODE_MOVE) && sok_reg)
                    begin
                        // source cell needs its own read-modify-write
                        mem_re     = 1'b1;
                        mem_raddr  = saddr_reg;
                        done_next  = 1'b0;
                        state_next = ST_SRC;
                    end
                end
            end
            ST_SRC:
            begin
                mem_we      = 1'b1;
                mem_waddr   = saddr_reg;
                mem_wdata   = mem_rdata & ~bits_reg;
                done_next   = 1'b1;
                status_next = lgrid_pkg::STATUS_OK;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            rows_reg    <= lgrid_pkg::ROWS_RESET;
            cols_reg    <= lgrid_pkg::COLS_RESET;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    lgrid_pkg::REG_ROWS: rows_reg <= wr_data;
                    lgrid_pkg::REG_COLS: cols_reg <= wr_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        mode_reg   <= mode_next;
        bits_reg   <= bits_next;
        taddr_reg  <= taddr_next;
        saddr_reg  <= saddr_next;
        sok_reg    <= sok_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign status = status_reg;

    // no result can come out of the clearing pass
    a_no_done_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) != ST_CLEAR))
        else $error("result after clear state");

    // source step only follows a target evaluation
    a_src_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRC) |-> ($past(state_reg) == ST_EVAL))
        else $error("source step without evaluation");

    // source and target of a move are distinct cells
    a_src_not_target: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRC) |-> (saddr_reg != taddr_reg))
        else $error("move source equals target");

    // read and write never hit the same cell in one cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write to same cell");

    // busy drops only together with a result or at the end of the clear
    a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (done || ($past(state_reg) == ST_CLEAR)))
        else $error("busy fell without result");

endmodule
